@@ hdl/lppd_pkg.sv @@
`default_nettype none

package lppd_pkg;

  localparam int SPACING_W   = 32;
  localparam int LENGTH_W    = 16;
  localparam int THRESH_W    = 32;
  localparam int S2_W        = 2 * SPACING_W;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH  = 2'd2;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 32'd55487;
  localparam logic [LENGTH_W-1:0]  LENGTH_RESET  = 16'd11;
  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 32'd28;

  localparam int OUT_TDATA_W       = 8;
  localparam int OUT_LASER_ON      = 0;
  localparam int OUT_PULSE_STARTED = 1;
  localparam int OUT_HEAD_STOPPED  = 2;

  typedef enum logic [2:0] {
    OP_MX,
    OP_MY,
    OP_SS,
    OP_EE,
    OP_EM
  } mul_op_t;

endpackage

`default_nettype wire

@@ hdl/laser_pulses_per_distance.sv @@
// Laser pulse gate driven by servo ticks.
// Input stream s_axis: one word per servo tick, holding the signed X and Y
// travel of that tick. Output stream m_axis: one word per tick with the laser
// level, a pulse-start flag and a head-stopped flag.
// Configuration: cfg_wr_en / cfg_index / cfg_data write the pulse spacing
// (index 0), pulse length in ticks (index 1) and squared stop threshold
// (index 2); write only while no tick is in flight.
// All squares and the spacing test run through one shift-and-add multiplier
// that retires one multiplier bit per cycle, so the work per tick follows the
// widths: a stopped head or a lit laser needs only the squares of X and Y;
// with the laser off and the head moving, the spacing square, tick-count square
// and spacing test follow. One tick is worked on at a time; s_axis_tready
// rises the cycle after its result is loaded into the output register.
// The output register holds a finished word while m_axis_tready is low; the
// next tick may be accepted meanwhile, but its result waits until the word
// is taken.
// Synchronous reset turns the laser off, clears both counters, restores the
// register defaults and empties the output register.
`default_nettype none

module laser_pulses_per_distance #(
  parameter int DELTA_WIDTH = 24,
  parameter int COUNT_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [lppd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [lppd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // delta_x, delta_y, zero padding
  input  logic [((2*DELTA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // laser_on, pulse_started, head_stopped, zero padding
  output logic [lppd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
  import lppd_pkg::*;

  localparam int M_W   = 2 * DELTA_WIDTH + 1;
  localparam int E2_W  = 2 * COUNT_WIDTH;
  localparam int P_W   = M_W + E2_W;
  localparam int CNT_W = $clog2(E2_W + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_STEP,
    S_DONE
  } state_t;

  state_t                  state;
  mul_op_t                 op;
  logic [P_W-1:0]          mcand;
  logic [E2_W-1:0]         mplier;
  logic [P_W-1:0]          acc;
  logic [CNT_W-1:0]        cnt;
  logic [DELTA_WIDTH-1:0]  ay_reg;
  logic [M_W-1:0]          m_val;
  logic [S2_W-1:0]         s2;
  logic                    stopped;
  logic                    started;
  logic                    laser;
  logic [LENGTH_W-1:0]     on_cnt;
  logic [COUNT_WIDTH-1:0]  ticks;

  logic [SPACING_W-1:0]    spacing;
  logic [LENGTH_W-1:0]     length;
  logic [THRESH_W-1:0]     thresh;

  logic [DELTA_WIDTH-1:0]  dx;
  logic [DELTA_WIDTH-1:0]  dy;
  logic [DELTA_WIDTH-1:0]  ax;
  logic [DELTA_WIDTH-1:0]  ay;
  logic [LENGTH_W-1:0]     on_cnt_next;
  logic [COUNT_WIDTH-1:0]  ticks_next;
  logic [M_W-1:0]          m_cur;
  logic [OUT_TDATA_W-1:0]  out_word;

  assign dx = s_axis_tdata[DELTA_WIDTH-1:0];
  assign dy = s_axis_tdata[2*DELTA_WIDTH-1:DELTA_WIDTH];
  assign ax = dx[DELTA_WIDTH-1] ? DELTA_WIDTH'(~dx + 1'b1) : dx;
  assign ay = dy[DELTA_WIDTH-1] ? DELTA_WIDTH'(~dy + 1'b1) : dy;

  assign on_cnt_next = (laser && on_cnt != '1) ? LENGTH_W'(on_cnt + 1'b1) : on_cnt;
  assign ticks_next  = (ticks != '1) ? COUNT_WIDTH'(ticks + 1'b1) : ticks;

  assign m_cur         = acc[M_W-1:0];
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    out_word                    = '0;
    out_word[OUT_LASER_ON]      = laser;
    out_word[OUT_PULSE_STARTED] = started;
    out_word[OUT_HEAD_STOPPED]  = stopped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
      length  <= LENGTH_RESET;
      thresh  <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPACING: spacing <= cfg_data[SPACING_W-1:0];
        REG_LENGTH:  length  <= cfg_data[LENGTH_W-1:0];
        REG_THRESH:  thresh  <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      laser         <= 1'b0;
      on_cnt        <= '0;
      ticks         <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            on_cnt  <= on_cnt_next;
            ticks   <= ticks_next;
            ay_reg  <= ay;
            started <= 1'b0;
            op      <= OP_MX;
            mcand   <= P_W'(ax);
            mplier  <= E2_W'(ax);
            acc     <= '0;
            cnt     <= CNT_W'(DELTA_WIDTH);
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          unique case (op)
            OP_MX: begin
              op     <= OP_MY;
              mcand  <= P_W'(ay_reg);
              mplier <= E2_W'(ay_reg);
              cnt    <= CNT_W'(DELTA_WIDTH);
              state  <= S_MUL;
            end
            OP_MY: begin
              m_val   <= m_cur;
              stopped <= (m_cur < M_W'(thresh));
              priority if (m_cur < M_W'(thresh)) begin
                laser  <= 1'b0;
                on_cnt <= '0;
                ticks  <= '0;
                state  <= S_DONE;
              end else if (laser) begin
                if (on_cnt > length) begin
                  laser  <= 1'b0;
                  on_cnt <= '0;
                end
                state <= S_DONE;
              end else begin
                op     <= OP_SS;
                mcand  <= P_W'(spacing);
                mplier <= E2_W'(spacing);
                acc    <= '0;
                cnt    <= CNT_W'(SPACING_W);
                state  <= S_MUL;
              end
            end
            OP_SS: begin
              s2     <= acc[S2_W-1:0];
              op     <= OP_EE;
              mcand  <= P_W'(ticks);
              mplier <= E2_W'(ticks);
              acc    <= '0;
              cnt    <= CNT_W'(COUNT_WIDTH);
              state  <= S_MUL;
            end
            OP_EE: begin
              op     <= OP_EM;
              mcand  <= P_W'(m_val);
              mplier <= acc[E2_W-1:0];
              acc    <= '0;
              cnt    <= CNT_W'(E2_W);
              state  <= S_MUL;
            end
            OP_EM: begin
              if (acc > P_W'(s2)) begin
                laser   <= 1'b1;
                on_cnt  <= '0;
                ticks   <= '0;
                started <= 1'b1;
              end
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= out_word;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/lppd_chk.sv @@
`default_nettype none

module lppd_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [lppd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import lppd_pkg::*;

  // a new pulse always leaves the laser on
  a_start_sets_laser: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_PULSE_STARTED] |-> m_axis_tdata[OUT_LASER_ON])
    else $error("pulse started with laser off");

  // a stopped head forces the laser off and starts nothing
  a_stop_forces_off: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_HEAD_STOPPED]
      |-> !m_axis_tdata[OUT_LASER_ON] && !m_axis_tdata[OUT_PULSE_STARTED])
    else $error("laser on while head stopped");

  // one tick in flight: input closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

endmodule

bind laser_pulses_per_distance lppd_chk u_lppd_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
